// ===== src/quaternion_arith_unit_defines.svh =====
// ---------------------------------------------------------------------------
// quaternion_arith_unit_defines.svh
// Assertion macros shared by the quaternion arithmetic unit.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ARITH_UNIT_DEFINES_SVH
`define QUATERNION_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define QAU_ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("qau: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define QAU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("qau: next-cycle check failed");

`endif

// ===== src/qau_pkg.sv =====
// ---------------------------------------------------------------------------
// qau_pkg
// Shared constants and types of the quaternion arithmetic unit.
// ---------------------------------------------------------------------------
package qau_pkg;

    // default fixed-point format: Q1.14 in 16 bits
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int FUNC_W = 3;

    // function codes; 5..7 are unknown and give an all-zero word
    typedef enum logic [FUNC_W-1:0] {
        FUNC_MUL  = 3'd0,
        FUNC_CONJ = 3'd1,
        FUNC_DOT  = 3'd2,
        FUNC_ROT  = 3'd3,
        FUNC_MAT  = 3'd4
    } func_t;

endpackage

// ===== src/qau_mul_reg.sv =====
// ---------------------------------------------------------------------------
// qau_mul_reg
// Signed multiplier with a registered full-width product and load enable.
// ---------------------------------------------------------------------------
module qau_mul_reg
    import qau_pkg::*;
#(
    parameter int AW = DATA_WIDTH_DEF,
    parameter int BW = DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  prod
);

    logic signed [AW+BW-1:0] prod_reg;

    // exact product, held while the stage stalls
    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/quaternion_arith_unit.sv =====
// An accepted input word reaches m_valid on an idle output through five register
//   stages, the input register being the first. Throughput: one word per cycle
//   unless m_ready stalls the output; stages 1 and 3 each hold one bank of signed
//   multipliers (16 and 9), every stage has its own valid bit and bubbles collapse.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers
//   keep their contents and are ignored until refilled.
// ---------------------------------------------------------------------------
// quaternion_arith_unit
// Pipelined fixed-point quaternion unit: product, conjugate, dot, vector
// rotation and quaternion-to-matrix conversion with saturation.
// ---------------------------------------------------------------------------
`include "quaternion_arith_unit_defines.svh"

module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [FUNC_W-1:0]            s_func,
    input  logic signed [DATA_WIDTH-1:0] s_a_x,
    input  logic signed [DATA_WIDTH-1:0] s_a_y,
    input  logic signed [DATA_WIDTH-1:0] s_a_z,
    input  logic signed [DATA_WIDTH-1:0] s_a_w,
    input  logic signed [DATA_WIDTH-1:0] s_b_x,
    input  logic signed [DATA_WIDTH-1:0] s_b_y,
    input  logic signed [DATA_WIDTH-1:0] s_b_z,
    input  logic signed [DATA_WIDTH-1:0] s_b_w,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_res_0,
    output logic signed [DATA_WIDTH-1:0] m_res_1,
    output logic signed [DATA_WIDTH-1:0] m_res_2,
    output logic signed [DATA_WIDTH-1:0] m_res_3,
    output logic signed [DATA_WIDTH-1:0] m_res_4,
    output logic signed [DATA_WIDTH-1:0] m_res_5,
    output logic signed [DATA_WIDTH-1:0] m_res_6,
    output logic signed [DATA_WIDTH-1:0] m_res_7,
    output logic signed [DATA_WIDTH-1:0] m_res_8,
    output logic                         m_saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int FM1 = FRAC_BITS - 1;
    localparam int PW  = 2 * W;         // first-bank product
    localparam int QW  = 2 * W + 1;     // rotate-bank product
    localparam int TW  = W + 1;         // clamped cross product
    // wide sum width: room for four products and the constant 1.0
    localparam int SW  = ((2 * W > F + 1) ? 2 * W : F + 1) + 3;
    localparam int NST = 5;
    localparam int NRES = 9;

    localparam logic signed [SW-1:0] ONE     = {{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [SW-1:0] RES_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] RES_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] T_MAX   = {{(SW-W){1'b0}}, {W{1'b1}}};
    localparam logic signed [SW-1:0] T_MIN   = {{(SW-W){1'b1}}, {W{1'b0}}};

    // rotate bank operands: A index (x,y,z,w = 0..3) and t index per multiplier
    localparam int ROT_A [9] = '{3, 3, 3, 1, 2, 2, 0, 0, 1};
    localparam int ROT_T [9] = '{0, 1, 2, 2, 1, 0, 2, 1, 0};

    // ------------------------------------------------------------------
    // Stage control: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] stage_en;

    always_comb begin
        stage_en[NST-1] = !valid_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) valid_reg[0] <= s_valid;
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input word register
    // ------------------------------------------------------------------
    func_t                func0_reg;
    logic signed [W-1:0]  a0_reg [4];
    logic signed [W-1:0]  b0_reg [4];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            func0_reg <= func_t'(s_func);
            a0_reg[0] <= s_a_x;
            a0_reg[1] <= s_a_y;
            a0_reg[2] <= s_a_z;
            a0_reg[3] <= s_a_w;
            b0_reg[0] <= s_b_x;
            b0_reg[1] <= s_b_y;
            b0_reg[2] <= s_b_z;
            b0_reg[3] <= s_b_w;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: 4x4 product bank; matrix conversion squares A with itself
    // ------------------------------------------------------------------
    logic signed [W-1:0]  bsel [4];
    logic signed [PW-1:0] p1 [4][4];
    func_t                func1_reg;
    logic signed [W-1:0]  a1_reg [4];
    logic signed [W-1:0]  b1_reg [3];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            bsel[j] = (func0_reg == FUNC_MAT) ? a0_reg[j] : b0_reg[j];
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_row1
        for (genvar j = 0; j < 4; j++) begin : g_col1
            qau_mul_reg #(.AW(W), .BW(W)) u_mul (
                .clk  (aclk),
                .en   (stage_en[1]),
                .a    (a0_reg[i]),
                .b    (bsel[j]),
                .prod (p1[i][j])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            func1_reg <= func0_reg;
            a1_reg    <= a0_reg;
            for (int j = 0; j < 3; j++) b1_reg[j] <= b0_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: truncate and sum products; rotate cross product clamped
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r2_next [NRES];
    logic signed [TW-1:0] t2_next [3];
    logic                 sat2_next;
    logic signed [SW-1:0] r2_reg [NRES];
    logic signed [TW-1:0] t2_reg [3];
    logic                 sat2_reg;
    func_t                func2_reg;
    logic signed [W-1:0]  a2_reg [4];
    logic signed [W-1:0]  b2_reg [3];

    always_comb begin
        logic signed [SW-1:0] s [4][4];   // floor(p / 2^F)
        logic signed [SW-1:0] d [4][4];   // floor(p / 2^(F-1)), doubled product
        logic signed [SW-1:0] tc [3];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                s[i][j] = SW'(p1[i][j]) >>> F;
                d[i][j] = SW'(p1[i][j]) >>> FM1;
            end
        end
        tc[0] = d[1][2] - d[2][1];
        tc[1] = d[2][0] - d[0][2];
        tc[2] = d[0][1] - d[1][0];

        for (int k = 0; k < NRES; k++) r2_next[k] = '0;
        for (int k = 0; k < 3; k++) t2_next[k] = '0;
        sat2_next = 1'b0;

        case (func1_reg)
            FUNC_MUL: begin
                r2_next[0] = s[3][0] + s[0][3] + s[1][2] - s[2][1];
                r2_next[1] = s[3][1] - s[0][2] + s[1][3] + s[2][0];
                r2_next[2] = s[3][2] + s[0][1] - s[1][0] + s[2][3];
                r2_next[3] = s[3][3] - s[0][0] - s[1][1] - s[2][2];
            end
            FUNC_CONJ: begin
                r2_next[0] = -SW'(a1_reg[0]);
                r2_next[1] = -SW'(a1_reg[1]);
                r2_next[2] = -SW'(a1_reg[2]);
                r2_next[3] = SW'(a1_reg[3]);
            end
            FUNC_DOT: begin
                r2_next[0] = s[0][0] + s[1][1] + s[2][2] + s[3][3];
            end
            FUNC_ROT: begin
                for (int k = 0; k < 3; k++) begin
                    if (tc[k] > T_MAX) begin
                        t2_next[k] = T_MAX[TW-1:0];
                        sat2_next  = 1'b1;
                    end else if (tc[k] < T_MIN) begin
                        t2_next[k] = T_MIN[TW-1:0];
                        sat2_next  = 1'b1;
                    end else begin
                        t2_next[k] = tc[k][TW-1:0];
                    end
                end
            end
            FUNC_MAT: begin
                // B was replaced by A, so d[i][j] is the doubled A_i*A_j
                r2_next[0] = ONE - (d[1][1] + d[2][2]);
                r2_next[1] = d[0][1] - d[3][2];
                r2_next[2] = d[0][2] + d[3][1];
                r2_next[3] = d[0][1] + d[3][2];
                r2_next[4] = ONE - (d[0][0] + d[2][2]);
                r2_next[5] = d[1][2] - d[3][0];
                r2_next[6] = d[0][2] - d[3][1];
                r2_next[7] = d[1][2] + d[3][0];
                r2_next[8] = ONE - (d[0][0] + d[1][1]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            r2_reg    <= r2_next;
            t2_reg    <= t2_next;
            sat2_reg  <= sat2_next;
            func2_reg <= func1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotate bank, A times clamped cross product
    // ------------------------------------------------------------------
    logic signed [QW-1:0] q3 [9];
    logic signed [SW-1:0] r3_reg [NRES];
    logic                 sat3_reg;
    func_t                func3_reg;
    logic signed [W-1:0]  b3_reg [3];

    for (genvar k = 0; k < 9; k++) begin : g_rot
        qau_mul_reg #(.AW(W), .BW(TW)) u_mul (
            .clk  (aclk),
            .en   (stage_en[3]),
            .a    (a2_reg[ROT_A[k]]),
            .b    (t2_reg[ROT_T[k]]),
            .prod (q3[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            r3_reg    <= r2_reg;
            sat3_reg  <= sat2_reg;
            func3_reg <= func2_reg;
            b3_reg    <= b2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: finish rotation, saturate every field, output register
    // ------------------------------------------------------------------
    logic signed [W-1:0] res_next [NRES];
    logic                sat_next;
    logic signed [W-1:0] res_reg [NRES];
    logic                sat_reg;

    always_comb begin
        logic signed [SW-1:0] qs [9];
        logic signed [SW-1:0] rf [NRES];
        for (int k = 0; k < 9; k++) qs[k] = SW'(q3[k]) >>> F;
        rf = r3_reg;
        if (func3_reg == FUNC_ROT) begin
            rf[0] = SW'(b3_reg[0]) + qs[0] + qs[3] - qs[4];
            rf[1] = SW'(b3_reg[1]) + qs[1] + qs[5] - qs[6];
            rf[2] = SW'(b3_reg[2]) + qs[2] + qs[7] - qs[8];
        end
        sat_next = sat3_reg;
        for (int k = 0; k < NRES; k++) begin
            if (rf[k] > RES_MAX) begin
                res_next[k] = RES_MAX[W-1:0];
                sat_next    = 1'b1;
            end else if (rf[k] < RES_MIN) begin
                res_next[k] = RES_MIN[W-1:0];
                sat_next    = 1'b1;
            end else begin
                res_next[k] = rf[k][W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_valid     = valid_reg[NST-1];
    assign m_res_0     = res_reg[0];
    assign m_res_1     = res_reg[1];
    assign m_res_2     = res_reg[2];
    assign m_res_3     = res_reg[3];
    assign m_res_4     = res_reg[4];
    assign m_res_5     = res_reg[5];
    assign m_res_6     = res_reg[6];
    assign m_res_7     = res_reg[7];
    assign m_res_8     = res_reg[8];
    assign m_saturated = sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic load_non_mat;
    logic upper_zero;

    // a word other than matrix conversion moves into the output register
    assign load_non_mat = valid_reg[3] && stage_en[4] && (func3_reg != FUNC_MAT);
    assign upper_zero   = (m_res_4 == '0) && (m_res_5 == '0) && (m_res_6 == '0)
                          && (m_res_7 == '0) && (m_res_8 == '0);

    // a full pipeline with a stalled output must refuse input
    `QAU_ASSERT_SAME(a_full_stall, aclk, aresetn, (valid_reg == '1) && !m_ready, !s_ready)
    // only matrix conversion fills the upper five fields
    `QAU_ASSERT_NEXT(a_upper_zero, aclk, aresetn, load_non_mat, upper_zero)
    // reset empties every stage
    `QAU_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, (valid_reg == '0) && !m_valid)

endmodule
